// File: design/cfde_pkg.sv
`default_nettype none

package cfde_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int OUT_WIDTH       = 26;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROOT,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// File: design/cfde_fifo.sv
`default_nettype none

module cfde_fifo #(
  parameter int WIDTH = 100
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire logic [WIDTH-1:0]       push_data,
  input  wire logic                   pop,
  output      logic [WIDTH-1:0]       pop_data,
  output      cfde_pkg::queue_status_t status
);
  import cfde_pkg::*;

  logic [WIDTH-1:0]       mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;

  assign status.full  = (count_r == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// File: design/cfde_front.sv
`default_nettype none

module cfde_front #(
  parameter int COORD_WIDTH = cfde_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [COORD_WIDTH-1:0]        face_x,
  input  wire logic [COORD_WIDTH-1:0]        face_y,
  input  wire logic [COORD_WIDTH-1:0]        face_z,
  input  wire logic [COORD_WIDTH-1:0]        centre_x,
  input  wire logic [COORD_WIDTH-1:0]        centre_y,
  input  wire logic [COORD_WIDTH-1:0]        centre_z,
  input  wire logic                          last_face,
  input  wire cfde_pkg::queue_status_t       q_status,
  output      logic                          push,
  output      logic [2*COORD_WIDTH+1:0]      push_max,
  output      logic [2*COORD_WIDTH+1:0]      push_min
);
  import cfde_pkg::*;

  localparam int C    = COORD_WIDTH;
  localparam int SQ_W = 2 * COORD_WIDTH + 2;

  function automatic logic [C-1:0] magnitude(input logic signed [C:0] d);
    logic signed [C:0] n;
    n = -d;
    return d[C] ? n[C-1:0] : d[C-1:0];
  endfunction

  logic [C-1:0] face   [3];
  logic [C-1:0] centre [3];

  logic             s1_valid_r, s2_valid_r, s3_valid_r;
  logic             s1_last_r, s2_last_r, s3_last_r;
  logic [C-1:0]     mag_r  [3];
  logic [2*C-1:0]   prod_r [3];
  logic [SQ_W-1:0]  sq_r;

  logic [SQ_W-1:0]  max_r, max_nxt;
  logic [SQ_W-1:0]  min_r, min_nxt;
  logic             first_r, first_nxt;
  logic [SQ_W-1:0]  new_max, new_min;
  logic             advance;
  logic             fire;

  assign face[0]   = face_x;
  assign face[1]   = face_y;
  assign face[2]   = face_z;
  assign centre[0] = centre_x;
  assign centre[1] = centre_y;
  assign centre[2] = centre_z;

  // hold the whole pipe while a finished cell cannot enter the queue
  assign advance  = !(s3_valid_r && s3_last_r && q_status.full);
  assign in_ready = advance;
  assign fire     = s3_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    always_ff @(posedge clk) begin
      if (advance) begin
        mag_r[a]  <= magnitude($signed({face[a][C-1], face[a]}) -
                               $signed({centre[a][C-1], centre[a]}));
        prod_r[a] <= mag_r[a] * mag_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last_r <= last_face;
      s2_last_r <= s1_last_r;
      s3_last_r <= s2_last_r;
      sq_r      <= SQ_W'(prod_r[0]) + SQ_W'(prod_r[1]) + SQ_W'(prod_r[2]);
    end
  end

  always_comb begin
    new_max   = first_r ? sq_r : ((sq_r > max_r) ? sq_r : max_r);
    new_min   = first_r ? sq_r : ((sq_r < min_r) ? sq_r : min_r);
    max_nxt   = max_r;
    min_nxt   = min_r;
    first_nxt = first_r;
    if (fire) begin
      if (s3_last_r) begin
        max_nxt   = '0;
        min_nxt   = '0;
        first_nxt = 1'b1;
      end else begin
        max_nxt   = new_max;
        min_nxt   = new_min;
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= '0;
      min_r   <= '0;
      first_r <= 1'b1;
    end else begin
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      first_r <= first_nxt;
    end
  end

  assign push     = fire && s3_last_r;
  assign push_max = new_max;
  assign push_min = new_min;

endmodule

`default_nettype wire

// File: design/cfde_back.sv
`default_nettype none

module cfde_back #(
  parameter int COORD_WIDTH = cfde_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cfde_pkg::queue_status_t       q_status,
  output      logic                          pop,
  input  wire logic [2*COORD_WIDTH+1:0]      pop_max,
  input  wire logic [2*COORD_WIDTH+1:0]      pop_min,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [cfde_pkg::OUT_WIDTH-1:0] extent_max,
  output      logic [cfde_pkg::OUT_WIDTH-1:0] extent_min
);
  import cfde_pkg::*;

  localparam int RT_W    = COORD_WIDTH + 1;
  localparam int ITERS   = (RT_W + 1) / 2;
  localparam int N_STEPS = 2 * ITERS;
  localparam int PAD_W   = 2 * N_STEPS;
  localparam int REM_W   = N_STEPS + 2;
  localparam int CNT_W   = $clog2(ITERS);
  localparam int CMP_W   = (N_STEPS > OUT_WIDTH) ? N_STEPS : OUT_WIDTH;
  localparam logic [CMP_W-1:0]     HALF_MAX = CMP_W'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
  localparam logic [OUT_WIDTH-1:0] OUT_MAX  = '1;

  back_state_t state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PAD_W-1:0]   rad_r  [2];
  logic [REM_W-1:0]   rem_r  [2];
  logic [N_STEPS-1:0] root_r [2];
  logic [PAD_W-1:0]   rad_nxt  [2];
  logic [REM_W-1:0]   rem_nxt  [2];
  logic [N_STEPS-1:0] root_nxt [2];
  logic [OUT_WIDTH-1:0] twice [2];

  logic                 load_root;
  logic                 load_out;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_WIDTH-1:0] ext_max_r, ext_min_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = B_ROOT;
        end
      end
      B_ROOT: begin
        if (cnt_r == CNT_W'(ITERS - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    load_root = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      B_IDLE:  load_root = !q_status.empty;
      B_ROOT:  load_root = 1'b0;
      B_DONE:  load_out  = !out_valid_r || out_ready;
      default: load_out  = 1'b0;
    endcase
  end

  assign pop = load_root;

  // two root digits a cycle for each of the two values
  for (genvar u = 0; u < 2; u++) begin : g_unit
    always_comb begin
      logic [REM_W-1:0]   rem;
      logic [N_STEPS-1:0] root;
      logic [REM_W-1:0]   rem_t;
      logic [REM_W-1:0]   trial;
      rem  = rem_r[u];
      root = root_r[u];
      for (int k = 0; k < 2; k++) begin
        rem_t = {rem[REM_W-3:0], rad_r[u][PAD_W-1-2*k -: 2]};
        trial = {root, 2'b01};
        if (rem_t >= trial) begin
          rem  = rem_t - trial;
          root = {root[N_STEPS-2:0], 1'b1};
        end else begin
          rem  = rem_t;
          root = {root[N_STEPS-2:0], 1'b0};
        end
      end
      rem_nxt[u]  = rem;
      root_nxt[u] = root;
      rad_nxt[u]  = {rad_r[u][PAD_W-5:0], 4'b0000};
    end

    always_comb begin
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(root_r[u]);
      twice[u] = (ext > HALF_MAX) ? OUT_MAX : OUT_WIDTH'(ext << 1);
    end

    always_ff @(posedge clk) begin
      if (load_root) begin
        rad_r[u]  <= (u == 0) ? PAD_W'(pop_max) : PAD_W'(pop_min);
        rem_r[u]  <= '0;
        root_r[u] <= '0;
      end else if (state_r == B_ROOT) begin
        rad_r[u]  <= rad_nxt[u];
        rem_r[u]  <= rem_nxt[u];
        root_r[u] <= root_nxt[u];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (load_root) begin
      cnt_nxt = '0;
    end else if (state_r == B_ROOT) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ext_max_r <= twice[0];
      ext_min_r <= twice[1];
    end
  end

  assign out_valid  = out_valid_r;
  assign extent_max = ext_max_r;
  assign extent_min = ext_min_r;

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == B_IDLE))
    else $error("queue read outside idle state");

  a_load_enters_root: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == B_ROOT) && (cnt_r == '0))
    else $error("root iteration did not start after queue read");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// File: design/cell_face_distance_extent.sv
// Per-cell face distance extent.
// Input stream: one beat per mesh face. in_tdata carries the face centre and
// the owning cell centre as signed fixed-point coordinates; in_tlast marks the
// last face of a cell. Output stream: one beat per cell, carrying twice the
// floored root of the largest and of the smallest squared face-to-centre
// distance of that cell.
// Throughput: one face per cycle into the front pipe while in_tready is high.
// The root unit takes one cell at a time from the queue and works on it in
// ITERS root iterations (ITERS = (COORD_WIDTH + 2) / 2, two root digits a
// cycle, both roots side by side); it takes no new cell until it has written
// the result to the output register. A four-deep queue of finished cells
// sits between the front pipe and the root unit.
// Reset: running extents clear, the queue empties, out_tvalid drops.
// Stall: the output register holds its beat while out_tready is low; the root
// unit then waits, the queue fills, and in_tready drops once a last face
// reaches the end of the front pipe while the queue is full.
`default_nettype none

module cell_face_distance_extent #(
  parameter int COORD_WIDTH = cfde_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output      logic                                      in_tready,
  // face_x, face_y, face_z, centre_x, centre_y, centre_z, zero pad
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]        in_tdata,
  input  wire logic                                      in_tlast,
  output      logic                                      out_tvalid,
  input  wire logic                                      out_tready,
  // extent_max, extent_min, zero pad
  output      logic [((2*cfde_pkg::OUT_WIDTH+7)/8)*8-1:0] out_tdata
);
  import cfde_pkg::*;

  localparam int C        = COORD_WIDTH;
  localparam int SQ_W     = 2 * COORD_WIDTH + 2;
  localparam int IN_DW    = ((6 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DW   = ((2 * OUT_WIDTH + 7) / 8) * 8;
  localparam int IN_PAD   = IN_DW - 6 * COORD_WIDTH;
  localparam int OUT_PAD  = OUT_DW - 2 * OUT_WIDTH;

  queue_status_t        q_status;
  logic                 push, pop;
  logic [SQ_W-1:0]      push_max, push_min;
  logic [2*SQ_W-1:0]    pop_data;
  logic [OUT_WIDTH-1:0] extent_max, extent_min;

  cfde_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .face_x   (in_tdata[0*C +: C]),
    .face_y   (in_tdata[1*C +: C]),
    .face_z   (in_tdata[2*C +: C]),
    .centre_x (in_tdata[3*C +: C]),
    .centre_y (in_tdata[4*C +: C]),
    .centre_z (in_tdata[5*C +: C]),
    .last_face(in_tlast),
    .q_status (q_status),
    .push     (push),
    .push_max (push_max),
    .push_min (push_min)
  );

  cfde_fifo #(
    .WIDTH(2 * SQ_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_min, push_max}),
    .pop      (pop),
    .pop_data (pop_data),
    .status   (q_status)
  );

  cfde_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .pop       (pop),
    .pop_max   (pop_data[SQ_W-1:0]),
    .pop_min   (pop_data[2*SQ_W-1:SQ_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .extent_max(extent_max),
    .extent_min(extent_min)
  );

  if (OUT_PAD > 0) begin : g_out_pad
    assign out_tdata = {{OUT_PAD{1'b0}}, extent_min, extent_max};
  end else begin : g_out_nopad
    assign out_tdata = {extent_min, extent_max};
  end

  if (IN_PAD > 0) begin : g_in_pad
    logic unused_pad;
    assign unused_pad = ^in_tdata[IN_DW-1:6*C];
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CW = cfde_pkg::COORD_WIDTH_DEF;
  localparam int OW = cfde_pkg::OUT_WIDTH;
  localparam int IN_W = ((6 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((2 * OW + 7) / 8) * 8;
  localparam int SQ_W = 2 * CW + 2;
  localparam int HOLD_CYCLES = 400;
  localparam longint LIMIT_NS = 64'd600_000 * 20;
  localparam logic [CW-1:0] C_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [OW-1:0] EXTENT_CAP = '1;

  typedef struct {
    logic [OW-1:0] ext_max;
    logic [OW-1:0] ext_min;
  } extent_t;

  class extent_scoreboard;
    logic [SQ_W-1:0] largest_sq;
    logic [SQ_W-1:0] smallest_sq;
    bit              first_face;
    extent_t         expected_extents[$];
    int              errors;
    int              faces_seen;
    int              cells_closed;
    int              extents_checked;

    function new();
      largest_sq = '0;
      smallest_sq = '0;
      first_face = 1'b1;
      errors = 0;
      faces_seen = 0;
      cells_closed = 0;
      extents_checked = 0;
    endfunction

    function logic [SQ_W-1:0] squared_reach(logic [IN_W-1:0] d);
      logic signed [CW:0] diff;
      logic [SQ_W-1:0]    mag;
      logic [SQ_W-1:0]    acc;
      acc = '0;
      for (int a = 0; a < 3; a++) begin
        diff = $signed({d[a*CW+CW-1], d[a*CW +: CW]})
             - $signed({d[(a+3)*CW+CW-1], d[(a+3)*CW +: CW]});
        if (diff < 0) diff = -diff;
        mag = '0;
        mag[CW:0] = diff;
        acc = acc + mag * mag;
      end
      return acc;
    endfunction

    function logic [OW-1:0] doubled_root(logic [SQ_W-1:0] v);
      logic [OW-1:0]     r;
      logic [OW-1:0]     t;
      logic [2*OW-1:0]   tt;
      r = '0;
      for (int b = OW - 1; b >= 0; b--) begin
        t = r | (OW'(1) << b);
        tt = {{OW{1'b0}}, t} * {{OW{1'b0}}, t};
        if (tt <= (2 * OW)'(v)) r = t;
      end
      if (r > (EXTENT_CAP >> 1)) return EXTENT_CAP;
      return OW'(r << 1);
    endfunction

    function void note_face(logic [IN_W-1:0] d, logic last);
      logic [SQ_W-1:0] sq;
      extent_t         e;
      sq = squared_reach(d);
      faces_seen++;
      if (first_face) begin
        largest_sq = sq;
        smallest_sq = sq;
        first_face = 1'b0;
      end else begin
        if (sq > largest_sq) largest_sq = sq;
        if (sq < smallest_sq) smallest_sq = sq;
      end
      if (last) begin
        e.ext_max = doubled_root(largest_sq);
        e.ext_min = doubled_root(smallest_sq);
        expected_extents.push_back(e);
        largest_sq = '0;
        smallest_sq = '0;
        first_face = 1'b1;
        cells_closed++;
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (errors < 40)
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_extent(logic [OUT_W-1:0] d);
      extent_t e;
      if (expected_extents.size() == 0) begin
        report_mismatch("beat with nothing pending", 64'(d), 64'd0);
        return;
      end
      e = expected_extents.pop_front();
      extents_checked++;
      if (d[OW-1:0] !== e.ext_max) report_mismatch("extent_max", 64'(d[OW-1:0]), 64'(e.ext_max));
      if (d[2*OW-1:OW] !== e.ext_min)
        report_mismatch("extent_min", 64'(d[2*OW-1:OW]), 64'(e.ext_min));
      if (d[OUT_W-1:2*OW] !== '0)
        report_mismatch("pad bits", 64'(d[OUT_W-1:2*OW]), 64'd0);
    endtask

    function int waiting();
      return expected_extents.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // face_x, face_y, face_z, centre_x, centre_y, centre_z, zero pad
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // extent_max, extent_min, zero pad
  logic [OUT_W-1:0] out_tdata;

  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  logic             pressure_go = 1'b0;
  logic             hold_off = 1'b0;
  extent_scoreboard sb;

  cell_face_distance_extent DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_extent(out_tdata);
  end

  // hold the output off long enough to back up the cell queue
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [IN_W-1:0] pack_face(logic [CW-1:0] fx, logic [CW-1:0] fy,
                                                 logic [CW-1:0] fz, logic [CW-1:0] cx,
                                                 logic [CW-1:0] cy, logic [CW-1:0] cz);
    return IN_W'({cz, cy, cx, fz, fy, fx});
  endfunction

  function automatic logic [CW-1:0] rand_offset();
    int unsigned   k;
    logic [CW-1:0] o;
    k = $urandom_range(0, CW - 1);
    o = CW'($urandom) & CW'((32'd1 << k) - 1);
    if ($urandom_range(0, 1) == 1) o = -o;
    return o;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return CW'($urandom);
    if (r < 8) return rand_offset();
    case ($urandom_range(0, 3))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_face(logic [IN_W-1:0] d, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_face(d, last);
  endtask

  task automatic send_cell(int n_faces);
    logic [CW-1:0] c[3];
    logic [CW-1:0] f[3];
    int unsigned   shape;
    shape = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) c[a] = rand_coord();
    for (int n = 0; n < n_faces; n++) begin
      for (int a = 0; a < 3; a++) begin
        if (shape < 6) f[a] = c[a] + rand_offset();
        else if (shape < 8) f[a] = rand_coord();
        else f[a] = ($urandom_range(0, 1) == 1) ? C_MIN : C_MAX;
      end
      send_face(pack_face(f[0], f[1], f[2], c[0], c[1], c[2]), n == n_faces - 1);
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_faces);
    int sent;
    int n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_faces) begin
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      send_cell(n);
      sent += n;
    end
  endtask

  task automatic directed_faces();
    // single-face cells at the corners of the range, at zero and with alternating bits
    send_face(pack_face(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b1);
    send_face(pack_face(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), 1'b1);
    send_face(pack_face('0, '0, '0, '0, '0, '0), 1'b1);
    send_face(pack_face(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 1'b1);
    send_face(pack_face(24'h555555, 24'hAAAAAA, 24'h555555,
                        24'hAAAAAA, 24'h555555, 24'hAAAAAA), 1'b1);
    // four faces: exact square, zero, one long axis, tiny last
    send_face(pack_face(CW'(3), CW'(4), '0, '0, '0, '0), 1'b0);
    send_face(pack_face('0, '0, '0, '0, '0, '0), 1'b0);
    send_face(pack_face(C_MIN, '0, '0, C_MAX, '0, '0), 1'b0);
    send_face(pack_face(CW'(1), CW'(1), '0, '0, '0, '0), 1'b1);
    // equal distances along each axis
    send_face(pack_face(CW'(5), '0, '0, '0, '0, '0), 1'b0);
    send_face(pack_face('0, CW'(5), '0, '0, '0, '0), 1'b0);
    send_face(pack_face('0, '0, CW'(5), '0, '0, '0), 1'b1);
    // distance one, then a growing second face on a perfect square; then a far single face
    send_face(pack_face('1, '0, '0, '0, '0, '0), 1'b0);
    send_face(pack_face(CW'(24), '0, '0, '0, '0, '0), 1'b1);
    send_face(pack_face('1, '1, '1, C_MIN, C_MIN, C_MIN), 1'b1);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_faces();
    run_phase(0, 0, 380);
    run_phase(46, 0, 330);
    run_phase(0, 46, 330);
    run_phase(16, 16, 330);
    pressure_go = 1'b1;
    run_phase(0, 0, 250);
    in_tvalid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d faces in %0d cells, %0d extents checked: range corners, ties,",
             sb.faces_seen, sb.cells_closed, sb.extents_checked);
    $display("single-face cells, sender gaps, output stalls and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
